// File: rtl/bpl_pkg.sv
// Shared types, constants and saturation helpers for the bilinear patch point locator.
`default_nettype none
package bpl_pkg;

    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_STEPS   = 10;

    localparam int CFG_W   = 7;
    localparam int STEPS_W = 4;

    // configuration register indexes
    localparam logic CFG_GRID_COLUMNS = 1'b0;
    localparam logic CFG_GRID_ROWS    = 1'b1;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_SINGULAR = 1'b1;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_LOCATE = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ADDR,
        ST_READ,
        ST_LERP_MUL,
        ST_LERP_SUM,
        ST_MAC_MUL,
        ST_MAC_ACC,
        ST_CHECK_LEN,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_DIV1_GO,
        ST_DIV1_WAIT,
        ST_DIV2_GO,
        ST_DIV2_WAIT,
        ST_UPDATE,
        ST_NEXT,
        ST_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_INIT,
        OP_ADDR,
        OP_READ,
        OP_LERP_MUL,
        OP_LERP_SUM,
        OP_MAC_MUL,
        OP_MAC_ACC,
        OP_SQRT_GO,
        OP_DIV1_GO,
        OP_DIV2_GO,
        OP_UPDATE,
        OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        LERP_A,
        LERP_B,
        LERP_G
    } t_lerp;

    typedef struct packed {
        t_op                op;
        t_lerp              lsel;
        logic [2:0]         cnt;
        logic               edge_v;
        logic               status;
        logic [STEPS_W-1:0] steps;
    } t_cmd;

    typedef struct packed {
        logic sqrt_busy;
        logic div_busy;
        logic lsq_zero;
        logic both_zero;
    } t_stat;

    localparam logic signed [63:0] S32_HI = 64'sd2147483647;
    localparam logic signed [63:0] S32_LO = -64'sd2147483648;
    localparam logic signed [63:0] S31_HI = 64'sd1073741823;
    localparam logic signed [63:0] S31_LO = -64'sd1073741824;
    localparam logic signed [63:0] RS_HI  = 64'sd16777216;
    localparam logic signed [63:0] RS_LO  = -64'sd16777216;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = (x > S32_HI) ? S32_HI : ((x < S32_LO) ? S32_LO : x);
        return 32'(y);
    endfunction

    function automatic logic signed [30:0] clamp31(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = (x > S31_HI) ? S31_HI : ((x < S31_LO) ? S31_LO : x);
        return 31'(y);
    endfunction

    function automatic logic signed [25:0] clamp_rs(input logic signed [63:0] x);
        logic signed [63:0] y;
        y = (x > RS_HI) ? RS_HI : ((x < RS_LO) ? RS_LO : x);
        return 26'(y);
    endfunction

endpackage
`default_nettype wire

// File: rtl/bpl_datapath.sv
// Datapath: grid stores, shared multiplier, bit-serial square root and divider, search state.
`default_nettype none
module bpl_datapath #(
    parameter int MAX_COLUMNS = bpl_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = bpl_pkg::DEF_MAX_ROWS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire bpl_pkg::t_cmd                i_cmd,
    output bpl_pkg::t_stat                    o_stat,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_index,
    input  wire logic [bpl_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic [5:0]                   i_col_index,
    input  wire logic [5:0]                   i_row_index,
    input  wire logic signed [31:0]           i_coord_x,
    input  wire logic signed [31:0]           i_coord_y,
    input  wire logic signed [31:0]           i_coord_z,
    output logic signed [31:0]                o_param_u,
    output logic signed [31:0]                o_param_v,
    output logic                              o_locate_status,
    output logic [bpl_pkg::STEPS_W-1:0]       o_steps_used
);
    import bpl_pkg::*;

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int NCW   = $clog2(MAX_COLUMNS + 1);
    localparam int NRW   = $clog2(MAX_ROWS + 1);
    localparam logic [4:0] SQ_ITER = 5'd31;
    localparam logic [5:0] DV_ITER = 6'd62;

    // grid stores
    logic signed [31:0] mem_x [DEPTH];
    logic signed [31:0] mem_y [DEPTH];
    logic signed [31:0] mem_z [DEPTH];
    logic signed [31:0] r_rd_x, r_rd_y, r_rd_z;

    // load address folding tables
    logic [CW-1:0] w_col_tab [64];
    logic [RW-1:0] w_row_tab [64];
    for (genvar gi = 0; gi < 64; gi++) begin : g_fold
        assign w_col_tab[gi] = CW'(gi % MAX_COLUMNS);
        assign w_row_tab[gi] = RW'(gi % MAX_ROWS);
    end

    logic [CFG_W-1:0] r_cfg_cols, r_cfg_rows;

    logic signed [31:0] r_q   [3];
    logic signed [31:0] r_pt  [4][3];
    logic signed [31:0] r_u, r_v;
    logic signed [25:0] r_r, r_s;
    logic [AW-1:0]      r_i00;
    logic signed [31:0] r_la, r_lb;
    logic signed [30:0] r_diff [3];
    logic signed [30:0] r_eu   [3];
    logic signed [30:0] r_ev   [3];
    logic signed [65:0] r_prod;
    logic signed [63:0] r_lsq, r_dot;
    logic               r_du_zero, r_dv_zero;

    // square root unit
    logic               r_sq_busy;
    logic [4:0]         r_sq_cnt;
    logic [61:0]        r_sq_n;
    logic [32:0]        r_sq_rem;
    logic [30:0]        r_sq_res;
    // divider unit
    logic               r_dv_busy;
    logic [5:0]         r_dv_cnt;
    logic [61:0]        r_dv_quo;
    logic [31:0]        r_dv_rem;

    logic [NCW-1:0]     w_cols;
    logic [NRW-1:0]     w_rows;
    logic [CW-1:0]      w_ci_max, w_ci;
    logic [RW-1:0]      w_rj_max, w_rj;
    logic [15:0]        w_u_int, w_v_int;
    logic [AW-1:0]      w_raddr, w_waddr;
    logic signed [32:0] w_ma, w_mb;
    logic signed [30:0] w_edge;
    logic signed [31:0] w_base, w_lerp;
    logic signed [63:0] w_step;

    always_comb begin
        w_cols = (r_cfg_cols < CFG_W'(2)) ? NCW'(2) :
                 ((32'(r_cfg_cols) > 32'(MAX_COLUMNS)) ? NCW'(MAX_COLUMNS) : NCW'(r_cfg_cols));
        w_rows = (r_cfg_rows < CFG_W'(2)) ? NRW'(2) :
                 ((32'(r_cfg_rows) > 32'(MAX_ROWS)) ? NRW'(MAX_ROWS) : NRW'(r_cfg_rows));
        w_ci_max = CW'(w_cols - NCW'(2));
        w_rj_max = RW'(w_rows - NRW'(2));
        w_u_int  = r_u[31] ? 16'd0 : r_u[31:16];
        w_v_int  = r_v[31] ? 16'd0 : r_v[31:16];
        w_ci = (32'(w_u_int) > 32'(w_ci_max)) ? w_ci_max : CW'(w_u_int);
        w_rj = (32'(w_v_int) > 32'(w_rj_max)) ? w_rj_max : RW'(w_v_int);

        case (i_cmd.cnt[1:0])
            2'd0:    w_raddr = r_i00;
            2'd1:    w_raddr = AW'(32'(r_i00) + 1);
            2'd2:    w_raddr = AW'(32'(r_i00) + MAX_COLUMNS);
            default: w_raddr = AW'(32'(r_i00) + MAX_COLUMNS + 1);
        endcase
        w_waddr = AW'(32'(w_row_tab[i_row_index]) * MAX_COLUMNS + 32'(w_col_tab[i_col_index]));

        w_edge = i_cmd.edge_v ? r_ev[0] : r_eu[0];
        if (i_cmd.op == OP_MAC_MUL) begin
            w_ma = 33'(w_edge);
            w_mb = i_cmd.cnt[0] ? 33'(r_diff[0]) : 33'(w_edge);
        end else begin
            w_ma = (i_cmd.lsel == LERP_G) ? 33'(r_s) : 33'(r_r);
            case (i_cmd.lsel)
                LERP_A:  w_mb = 33'(r_pt[1][0]) - 33'(r_pt[0][0]);
                LERP_B:  w_mb = 33'(r_pt[3][0]) - 33'(r_pt[2][0]);
                default: w_mb = 33'(r_lb) - 33'(r_la);
            endcase
        end

        case (i_cmd.lsel)
            LERP_A:  w_base = r_pt[0][0];
            LERP_B:  w_base = r_pt[2][0];
            default: w_base = r_la;
        endcase
        w_lerp = sat32(64'(w_base) + 64'(r_prod >>> 16));

        w_step = r_dot[63] ? -64'(r_dv_quo) : 64'(r_dv_quo);
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            mem_x[w_waddr] <= i_coord_x;
            mem_y[w_waddr] <= i_coord_y;
            mem_z[w_waddr] <= i_coord_z;
        end
        if (i_cmd.op == OP_READ) begin
            r_rd_x <= mem_x[w_raddr];
            r_rd_y <= mem_y[w_raddr];
            r_rd_z <= mem_z[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= CFG_W'(2);
            r_cfg_rows <= CFG_W'(2);
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_GRID_COLUMNS) r_cfg_cols <= i_cfg_data;
            else                                 r_cfg_rows <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_INIT: begin
                r_q[0] <= i_coord_x;
                r_q[1] <= i_coord_y;
                r_q[2] <= i_coord_z;
                r_u    <= '0;
                r_v    <= '0;
            end
            OP_ADDR: begin
                r_r   <= clamp_rs(64'(r_u) - (64'(w_ci) << 16));
                r_s   <= clamp_rs(64'(r_v) - (64'(w_rj) << 16));
                r_i00 <= AW'(32'(w_rj) * MAX_COLUMNS + 32'(w_ci));
            end
            OP_READ: begin
                // data of the previous address arrives through the read registers
                if (i_cmd.cnt != 3'd0) begin
                    r_pt[2'(i_cmd.cnt - 3'd1)][0] <= r_rd_x;
                    r_pt[2'(i_cmd.cnt - 3'd1)][1] <= r_rd_y;
                    r_pt[2'(i_cmd.cnt - 3'd1)][2] <= r_rd_z;
                end
            end
            OP_LERP_MUL, OP_MAC_MUL: r_prod <= w_ma * w_mb;
            OP_LERP_SUM: begin
                case (i_cmd.lsel)
                    LERP_A: r_la <= w_lerp;
                    LERP_B: r_lb <= w_lerp;
                    default: begin
                        r_diff[0] <= r_diff[1];
                        r_diff[1] <= r_diff[2];
                        r_diff[2] <= clamp31(64'(r_q[0]) - 64'(w_lerp));
                        r_eu[0]   <= r_eu[1];
                        r_eu[1]   <= r_eu[2];
                        r_eu[2]   <= clamp31(64'(r_pt[1][0]) - 64'(r_pt[0][0]));
                        r_ev[0]   <= r_ev[1];
                        r_ev[1]   <= r_ev[2];
                        r_ev[2]   <= clamp31(64'(r_pt[2][0]) - 64'(r_pt[0][0]));
                        // rotate so the next coordinate sits at slot 0
                        r_q[0] <= r_q[1];
                        r_q[1] <= r_q[2];
                        r_q[2] <= r_q[0];
                        for (int i = 0; i < 4; i++) begin
                            r_pt[i][0] <= r_pt[i][1];
                            r_pt[i][1] <= r_pt[i][2];
                            r_pt[i][2] <= r_pt[i][0];
                        end
                    end
                endcase
            end
            OP_MAC_ACC: begin
                if (!i_cmd.cnt[0]) begin
                    r_lsq <= (i_cmd.cnt == 3'd0) ? 64'(r_prod) : r_lsq + 64'(r_prod);
                end else begin
                    r_dot <= (i_cmd.cnt == 3'd1) ? 64'(r_prod) : r_dot + 64'(r_prod);
                    r_diff[0] <= r_diff[1];
                    r_diff[1] <= r_diff[2];
                    r_diff[2] <= r_diff[0];
                    r_eu[0]   <= r_eu[1];
                    r_eu[1]   <= r_eu[2];
                    r_eu[2]   <= r_eu[0];
                    r_ev[0]   <= r_ev[1];
                    r_ev[1]   <= r_ev[2];
                    r_ev[2]   <= r_ev[0];
                end
            end
            OP_UPDATE: begin
                if (i_cmd.edge_v) begin
                    r_v       <= sat32(64'(r_v) + w_step);
                    r_dv_zero <= (r_dv_quo == '0);
                end else begin
                    r_u       <= sat32(64'(r_u) + w_step);
                    r_du_zero <= (r_dv_quo == '0);
                end
            end
            OP_EMIT: begin
                o_param_u       <= r_u;
                o_param_v       <= r_v;
                o_locate_status <= i_cmd.status;
                o_steps_used    <= i_cmd.steps;
            end
            default: ;
        endcase
    end

    // floor square root, one result bit a cycle
    logic [34:0] w_sq_t, w_sq_trial;
    assign w_sq_t     = {r_sq_rem, r_sq_n[61:60]};
    assign w_sq_trial = {2'b00, r_sq_res, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_busy <= 1'b0;
        end else if (i_cmd.op == OP_SQRT_GO) begin
            r_sq_busy <= 1'b1;
            r_sq_cnt  <= SQ_ITER;
            r_sq_n    <= 62'(r_lsq);
            r_sq_rem  <= '0;
            r_sq_res  <= '0;
        end else if (r_sq_busy) begin
            if (w_sq_t >= w_sq_trial) begin
                r_sq_rem <= 33'(w_sq_t - w_sq_trial);
                r_sq_res <= {r_sq_res[29:0], 1'b1};
            end else begin
                r_sq_rem <= 33'(w_sq_t);
                r_sq_res <= {r_sq_res[29:0], 1'b0};
            end
            r_sq_n   <= {r_sq_n[59:0], 2'b00};
            r_sq_cnt <= r_sq_cnt - 5'd1;
            if (r_sq_cnt == 5'd1) r_sq_busy <= 1'b0;
        end
    end

    // restoring divider on magnitudes, one quotient bit a cycle
    logic [31:0] w_dv_t, w_dv_den;
    assign w_dv_t   = {r_dv_rem[30:0], r_dv_quo[61]};
    assign w_dv_den = {1'b0, r_sq_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
        end else if (i_cmd.op == OP_DIV1_GO || i_cmd.op == OP_DIV2_GO) begin
            r_dv_busy <= 1'b1;
            r_dv_cnt  <= DV_ITER;
            r_dv_rem  <= '0;
            if (i_cmd.op == OP_DIV1_GO) r_dv_quo <= r_dot[63] ? 62'(-r_dot) : 62'(r_dot);
            else                        r_dv_quo <= {r_dv_quo[45:0], 16'd0};
        end else if (r_dv_busy) begin
            if (w_dv_t >= w_dv_den) begin
                r_dv_rem <= w_dv_t - w_dv_den;
                r_dv_quo <= {r_dv_quo[60:0], 1'b1};
            end else begin
                r_dv_rem <= w_dv_t;
                r_dv_quo <= {r_dv_quo[60:0], 1'b0};
            end
            r_dv_cnt <= r_dv_cnt - 6'd1;
            if (r_dv_cnt == 6'd1) r_dv_busy <= 1'b0;
        end
    end

    assign o_stat.sqrt_busy = r_sq_busy;
    assign o_stat.div_busy  = r_dv_busy;
    assign o_stat.lsq_zero  = (r_lsq == '0);
    assign o_stat.both_zero = r_du_zero & r_dv_zero;

endmodule
`default_nettype wire

// File: rtl/bpl_ctrl.sv
// Controller: sequences loads, search steps and result hand-off.
`default_nettype none
module bpl_ctrl #(
    parameter int MAX_STEPS = bpl_pkg::DEF_MAX_STEPS
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_req_type,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output bpl_pkg::t_cmd        o_cmd,
    input  wire bpl_pkg::t_stat  i_stat
);
    import bpl_pkg::*;

    localparam int SW = $clog2(MAX_STEPS + 1);

    t_state        r_state, n_state;
    logic [2:0]    r_cnt, n_cnt;
    logic [1:0]    r_k, n_k;
    t_lerp         r_lsel, n_lsel;
    logic          r_edge, n_edge;
    logic [SW-1:0] r_step, n_step;
    logic          r_sing, n_sing;
    logic          r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
            r_lsel  <= LERP_A;
            r_edge  <= 1'b0;
            r_step  <= '0;
            r_sing  <= STATUS_OK;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_lsel  <= n_lsel;
            r_edge  <= n_edge;
            r_step  <= n_step;
            r_sing  <= n_sing;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_lsel  = r_lsel;
        n_edge  = r_edge;
        n_step  = r_step;
        n_sing  = r_sing;
        n_valid = r_valid & ~i_out_ready;
        o_cmd.op     = OP_NONE;
        o_cmd.lsel   = r_lsel;
        o_cmd.cnt    = r_cnt;
        o_cmd.edge_v = r_edge;
        o_cmd.status = r_sing;
        o_cmd.steps  = STEPS_W'(r_step);
        o_in_ready   = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_req_type == REQ_LOAD) begin
                        o_cmd.op = OP_LOAD;
                    end else begin
                        o_cmd.op = OP_INIT;
                        n_step   = SW'(1);
                        n_sing   = STATUS_OK;
                        n_state  = ST_ADDR;
                    end
                end
            end
            ST_ADDR: begin
                o_cmd.op = OP_ADDR;
                n_cnt    = '0;
                n_state  = ST_READ;
            end
            ST_READ: begin
                o_cmd.op = OP_READ;
                if (r_cnt == 3'd4) begin
                    n_k     = '0;
                    n_lsel  = LERP_A;
                    n_state = ST_LERP_MUL;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            ST_LERP_MUL: begin
                o_cmd.op = OP_LERP_MUL;
                n_state  = ST_LERP_SUM;
            end
            ST_LERP_SUM: begin
                o_cmd.op = OP_LERP_SUM;
                n_state  = ST_LERP_MUL;
                case (r_lsel)
                    LERP_A: n_lsel = LERP_B;
                    LERP_B: n_lsel = LERP_G;
                    default: begin
                        n_lsel = LERP_A;
                        if (r_k == 2'd2) begin
                            n_cnt   = '0;
                            n_edge  = 1'b0;
                            n_state = ST_MAC_MUL;
                        end else begin
                            n_k = r_k + 2'd1;
                        end
                    end
                endcase
            end
            ST_MAC_MUL: begin
                o_cmd.op = OP_MAC_MUL;
                n_state  = ST_MAC_ACC;
            end
            ST_MAC_ACC: begin
                o_cmd.op = OP_MAC_ACC;
                if (r_cnt == 3'd5) begin
                    n_state = ST_CHECK_LEN;
                end else begin
                    n_cnt   = r_cnt + 3'd1;
                    n_state = ST_MAC_MUL;
                end
            end
            ST_CHECK_LEN: begin
                if (i_stat.lsq_zero) begin
                    n_sing  = STATUS_SINGULAR;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_SQRT_GO;
                end
            end
            ST_SQRT_GO: begin
                o_cmd.op = OP_SQRT_GO;
                n_state  = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: if (!i_stat.sqrt_busy) n_state = ST_DIV1_GO;
            ST_DIV1_GO: begin
                o_cmd.op = OP_DIV1_GO;
                n_state  = ST_DIV1_WAIT;
            end
            ST_DIV1_WAIT: if (!i_stat.div_busy) n_state = ST_DIV2_GO;
            ST_DIV2_GO: begin
                o_cmd.op = OP_DIV2_GO;
                n_state  = ST_DIV2_WAIT;
            end
            ST_DIV2_WAIT: if (!i_stat.div_busy) n_state = ST_UPDATE;
            ST_UPDATE: begin
                o_cmd.op = OP_UPDATE;
                if (!r_edge) begin
                    n_edge  = 1'b1;
                    n_cnt   = '0;
                    n_state = ST_MAC_MUL;
                end else begin
                    n_state = ST_NEXT;
                end
            end
            ST_NEXT: begin
                if (i_stat.both_zero || r_step == SW'(MAX_STEPS)) begin
                    n_state = ST_EMIT;
                end else begin
                    n_step  = r_step + SW'(1);
                    n_state = ST_ADDR;
                end
            end
            ST_EMIT: begin
                if (!r_valid || i_out_ready) begin
                    o_cmd.op = OP_EMIT;
                    n_valid  = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_valid;

endmodule
`default_nettype wire

// File: rtl/bilinear_patch_point_locate.sv
// Top level: locates query points on a bilinear grid surface.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | i_in_valid/o_in_ready, req, index, coords    | in
//  out     | o_out_valid/i_out_ready, params, status, steps | out
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data            | in
//
// A load item is written to the grid stores while the block stays idle and ready. A query
// runs up to MAX_STEPS search steps: on each edge, each step runs the bit-serial square
// root and two divisions, which dominate.
// Reset clears control and sets both grid sizes to 2; grid stores are not cleared.
// A result waits in the output register while the next item is taken; a query only
// stalls at the end if the previous result is still held.
`default_nettype none
module bilinear_patch_point_locate #(
    parameter int MAX_COLUMNS = bpl_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = bpl_pkg::DEF_MAX_ROWS,
    parameter int MAX_STEPS   = bpl_pkg::DEF_MAX_STEPS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_req_type,
    input  wire logic [5:0]                   i_col_index,
    input  wire logic [5:0]                   i_row_index,
    input  wire logic signed [31:0]           i_coord_x,
    input  wire logic signed [31:0]           i_coord_y,
    input  wire logic signed [31:0]           i_coord_z,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic signed [31:0]                o_param_u,
    output logic signed [31:0]                o_param_v,
    output logic                              o_locate_status,
    output logic [bpl_pkg::STEPS_W-1:0]       o_steps_used,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_index,
    input  wire logic [bpl_pkg::CFG_W-1:0]    i_cfg_data
);
    import bpl_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    bpl_ctrl #(
        .MAX_STEPS (MAX_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    bpl_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_col_index     (i_col_index),
        .i_row_index     (i_row_index),
        .i_coord_x       (i_coord_x),
        .i_coord_y       (i_coord_y),
        .i_coord_z       (i_coord_z),
        .o_param_u       (o_param_u),
        .o_param_v       (o_param_v),
        .o_locate_status (o_locate_status),
        .o_steps_used    (o_steps_used)
    );

endmodule
`default_nettype wire

// File: rtl/bpl_checker.sv
// Port-level checks for the point locator, bound to the top level.
`default_nettype none
module bpl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        i_req_type,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] o_param_u,
    input wire logic [31:0] o_param_v,
    input wire logic [3:0]  o_steps_used
);
    // ready drops in the cycle after a query item is taken
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_req_type) |=> !o_in_ready)
        else $error("ready stayed high after a query item");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> ($stable(o_param_u) && $stable(o_param_v)))
        else $error("result payload changed while stalled");

    a_steps_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_steps_used != 4'd0))
        else $error("result with zero steps");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
endmodule

bind bilinear_patch_point_locate bpl_checker u_bpl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_req_type   (i_req_type),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_param_u    (o_param_u),
    .o_param_v    (o_param_v),
    .o_steps_used (o_steps_used)
);
`default_nettype wire
